### sv/swetr_pkg.sv
// Package for the single-wire edge-timed receiver.
// Holds shared widths, register indexes, reset values and the config struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swetr_pkg;

    localparam int STAMP_W  = 32;
    localparam int WORD_W   = 32;
    localparam int CNT_W    = 6;
    localparam int PERIOD_W = 16;
    localparam int ADDR_W   = 8;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_MODE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_PERIOD  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD    = 8'd3;

    // Reset values of the configuration registers
    localparam logic [ADDR_W-1:0]   RST_OWN_ADDRESS = 8'd0;
    localparam logic [PERIOD_W-1:0] RST_PULSE_PERIOD = 16'd10;
    localparam logic [PERIOD_W-1:0] RST_BIT_PERIOD   = 16'd100;

    // Result event kinds
    localparam logic EV_RESPOND = 1'b0;
    localparam logic EV_PAYLOAD = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0]   own_address;
        logic                listener_mode;
        logic [PERIOD_W-1:0] pulse_period;
        logic [PERIOD_W-1:0] bit_period;
    } t_cfg;

endpackage

`default_nettype wire

### sv/swetr_ifs.sv
// Channel interfaces of the single-wire edge-timed receiver:
// edge input, event output and configuration write channel.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface swetr_edge_if;
    logic        valid;
    logic        ready;
    logic [31:0] edge_time;
    logic        line_level;

    modport source (output valid, output edge_time, output line_level, input ready);
    modport sink   (input valid, input edge_time, input line_level, output ready);
endinterface

interface swetr_event_if;
    logic               valid;
    logic               ready;
    logic               event_kind;
    logic signed [31:0] payload;

    modport source (output valid, output event_kind, output payload, input ready);
    modport sink   (input valid, input event_kind, input payload, output ready);
endinterface

interface swetr_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/swetr_core.sv
// Frame decoder core: elapsed-time checks, skip counting and bit shifting.
// Holds the per-frame state; result is combinational for the output register.
// Depends on swetr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swetr_core #(
    parameter int ADDRESS_BITS = 8,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic [swetr_pkg::STAMP_W-1:0] i_edge_time,
    input  wire logic                          i_line_level,
    input  wire swetr_pkg::t_cfg               i_cfg,
    output logic                               o_res_vld,
    output logic                               o_event_kind,
    output logic [swetr_pkg::WORD_W-1:0]       o_payload
);
    import swetr_pkg::*;

    localparam logic [CNT_W-1:0] ADDR_CNT  = CNT_W'(ADDRESS_BITS);
    localparam logic [CNT_W-1:0] SKIP_LOAD = CNT_W'(PAYLOAD_BITS);

    logic [STAMP_W-1:0] r_last_stamp, n_last_stamp;
    logic [CNT_W-1:0]   r_bits, n_bits;
    logic [CNT_W-1:0]   r_skip, n_skip;
    logic [WORD_W-1:0]  r_shift, n_shift;

    logic [STAMP_W-1:0]    elapsed;
    logic [PERIOD_W+1:0]   glitch_lim;
    logic [PERIOD_W:0]     frame_lim;
    logic                  is_glitch;
    logic                  is_gap;
    logic [WORD_W-1:0]     shifted;
    logic [CNT_W-1:0]      bits_inc;
    logic [WORD_W-1:0]     ext_word;

    // Wrapping elapsed time and the two limits (3x pulse, 2x bit)
    assign elapsed    = i_edge_time - r_last_stamp;
    assign glitch_lim = {2'b00, i_cfg.pulse_period} + {1'b0, i_cfg.pulse_period, 1'b0};
    assign frame_lim  = {i_cfg.bit_period, 1'b0};
    assign is_glitch  = elapsed < STAMP_W'(glitch_lim);
    assign is_gap     = elapsed > STAMP_W'(frame_lim);

    assign shifted  = {r_shift[WORD_W-2:0], i_line_level};
    assign bits_inc = r_bits + CNT_W'(1);

    // Sign extension of the low payload bits of the new word
    always_comb begin
        for (int k = 0; k < WORD_W; k++) begin
            ext_word[k] = (k < PAYLOAD_BITS) ? shifted[k] : shifted[PAYLOAD_BITS-1];
        end
    end

    // Next state and result
    always_comb begin
        n_last_stamp = r_last_stamp;
        n_bits       = r_bits;
        n_skip       = r_skip;
        n_shift      = r_shift;
        o_res_vld    = 1'b0;
        o_event_kind = EV_RESPOND;
        o_payload    = '0;
        if (i_step && !is_glitch) begin
            n_last_stamp = i_edge_time;
            priority if (is_gap) begin
                n_bits  = '0;
                n_skip  = '0;
                n_shift = '0;
            end else if (r_skip != '0) begin
                n_skip = r_skip - CNT_W'(1);
            end else if (i_cfg.listener_mode) begin
                n_shift = shifted;
                n_bits  = bits_inc;
                if (bits_inc == ADDR_CNT) begin
                    n_bits  = '0;
                    n_shift = '0;
                    if (shifted == WORD_W'(i_cfg.own_address)) begin
                        o_res_vld    = 1'b1;
                        o_event_kind = EV_RESPOND;
                    end else begin
                        n_skip = SKIP_LOAD;
                    end
                end
            end else begin
                n_shift = shifted;
                n_bits  = bits_inc;
                if (bits_inc == SKIP_LOAD) begin
                    n_bits       = '0;
                    n_skip       = '0;
                    n_shift      = '0;
                    o_res_vld    = 1'b1;
                    o_event_kind = EV_PAYLOAD;
                    o_payload    = ext_word;
                end
            end
        end
    end

    // Frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_stamp <= '0;
            r_bits       <= '0;
            r_skip       <= '0;
            r_shift      <= '0;
        end else begin
            r_last_stamp <= n_last_stamp;
            r_bits       <= n_bits;
            r_skip       <= n_skip;
            r_shift      <= n_shift;
        end
    end

    // Skip count never exceeds one payload length
    a_skip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip <= SKIP_LOAD) else $error("skip counter out of range");

    // A glitch edge leaves the stored time alone
    a_glitch_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && is_glitch) |=> $stable(r_last_stamp))
        else $error("glitch edge moved the stored time");

    // Skipped edges never produce a result
    a_skip_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_skip != '0 && !is_gap) |-> !o_res_vld)
        else $error("result during skipped edges");

    // Respond events carry a zero payload
    a_respond_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && o_event_kind == EV_RESPOND) |-> (o_payload == '0))
        else $error("respond event with nonzero payload");

endmodule

`default_nettype wire

### sv/single_wire_edge_timed_receiver.sv
// Single-wire edge-timed receiver, top level.
//
// Channels: i_edge takes one line-edge event per transfer (timestamp in
// microseconds, line level after the edge). o_event gives a respond event
// (listener mode, address matched) or a received payload (caller mode).
// i_cfg writes one configuration register per transfer; it is always ready
// and is meant to be used only while the receiver is idle.
//
// Timing: an edge is captured in the input register on its transfer and
// decoded straight into the output register once that register is free or
// draining; a result thus passes the input and output registers in turn.
// One edge is taken per clock while i_edge.ready is high.
//
// Stall: the input register drains only into an empty or draining output
// register, so it holds while a result waits on o_event; i_edge.ready drops
// only when both registers are full and o_event.ready is low.
//
// Reset (i_rst_n low, synchronous): frame state, stored time and both
// pipeline registers clear; configuration returns to its reset values.
`timescale 1ns / 1ps
`default_nettype none

module single_wire_edge_timed_receiver #(
    parameter int ADDRESS_BITS = 8,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    swetr_edge_if.sink   i_edge,
    swetr_event_if.source o_event,
    swetr_cfg_if.sink    i_cfg
);
    import swetr_pkg::*;

    t_cfg r_cfg;

    logic               r_in_vld;
    logic [STAMP_W-1:0] r_in_time;
    logic               r_in_level;

    logic               r_out_vld;
    logic               r_out_kind;
    logic [WORD_W-1:0]  r_out_payload;

    logic               proc;
    logic               res_vld;
    logic               res_kind;
    logic [WORD_W-1:0]  res_payload;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_address   <= RST_OWN_ADDRESS;
            r_cfg.listener_mode <= 1'b0;
            r_cfg.pulse_period  <= RST_PULSE_PERIOD;
            r_cfg.bit_period    <= RST_BIT_PERIOD;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_OWN_ADDRESS:   r_cfg.own_address   <= i_cfg.data[ADDR_W-1:0];
                CFG_LISTENER_MODE: r_cfg.listener_mode <= i_cfg.data[0];
                CFG_PULSE_PERIOD:  r_cfg.pulse_period  <= i_cfg.data[PERIOD_W-1:0];
                CFG_BIT_PERIOD:    r_cfg.bit_period    <= i_cfg.data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: decode when the output register is free or draining
    assign proc         = r_in_vld && (!r_out_vld || o_event.ready);
    assign i_edge.ready = !r_in_vld || proc;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_edge.valid && i_edge.ready) begin
            r_in_vld <= 1'b1;
        end else if (proc) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_edge.valid && i_edge.ready) begin
            r_in_time  <= i_edge.edge_time;
            r_in_level <= i_edge.line_level;
        end
    end

    swetr_core #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (proc),
        .i_edge_time  (r_in_time),
        .i_line_level (r_in_level),
        .i_cfg        (r_cfg),
        .o_res_vld    (res_vld),
        .o_event_kind (res_kind),
        .o_payload    (res_payload)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (proc) begin
            r_out_vld <= res_vld;
        end else if (o_event.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && res_vld) begin
            r_out_kind    <= res_kind;
            r_out_payload <= res_payload;
        end
    end

    assign o_event.valid      = r_out_vld;
    assign o_event.event_kind = r_out_kind;
    assign o_event.payload    = r_out_payload;

endmodule

`default_nettype wire

### verif/single_wire_edge_timed_receiver_tb.sv
// Self-checking testbench for single_wire_edge_timed_receiver: random edge streams
// against a cycle-free frame decoder, with random stalls on both channels.
// Depends on swetr_pkg, the swetr channel interfaces and the receiver RTL.
`timescale 1ns / 1ps

module single_wire_edge_timed_receiver_tb;
    import swetr_pkg::*;

    localparam int ADDR_BITS = 8;
    localparam int PAY_BITS  = 32;
    localparam int LIMIT     = 400000;
    localparam int HOLD_LEN  = 400;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic               level;
    } t_edge_item;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] payload;
    } t_event_rec;

    logic i_clk;
    logic i_rst_n;

    swetr_edge_if  edge_if();
    swetr_event_if event_if();
    swetr_cfg_if   cfg_if();

    single_wire_edge_timed_receiver #(
        .ADDRESS_BITS(ADDR_BITS),
        .PAYLOAD_BITS(PAY_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_edge  (edge_if),
        .o_event (event_if),
        .i_cfg   (cfg_if)
    );

    // Pending edges and expected events
    t_edge_item edge_q[$];
    t_event_rec want_events[$];

    // Decoder copy of the receiver state and registers
    logic [STAMP_W-1:0]  prev_stamp;
    logic [CNT_W-1:0]    bits_seen;
    logic [CNT_W-1:0]    skip_count;
    logic [WORD_W-1:0]   shift_reg;
    logic [ADDR_W-1:0]   r_own;
    logic                r_listen;
    logic [PERIOD_W-1:0] r_pulse;
    logic [PERIOD_W-1:0] r_bitp;

    // Register values the edge generator shapes its gaps for
    logic [ADDR_W-1:0]   gen_own;
    logic                gen_listen;
    logic [PERIOD_W-1:0] gen_pulse;
    logic [PERIOD_W-1:0] gen_bitp;
    logic [STAMP_W-1:0]  gen_last;
    int                  queued;

    int  mismatches;
    int  cycles;
    int  send_gap;
    int  rx_stall;
    bit  edge_went;
    bit  rx_hold;
    bit  hold_go;
    bit  idle_ok;

    // Clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        edge_if.valid      = 1'b0;
        edge_if.edge_time  = '0;
        edge_if.line_level = 1'b0;
        event_if.ready     = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        prev_stamp = '0;
        bits_seen  = '0;
        skip_count = '0;
        shift_reg  = '0;
        r_own      = RST_OWN_ADDRESS;
        r_listen   = 1'b0;
        r_pulse    = RST_PULSE_PERIOD;
        r_bitp     = RST_BIT_PERIOD;
        mismatches = 0;
        cycles     = 0;
        send_gap   = 0;
        rx_stall   = 0;
        edge_went  = 1'b0;
        rx_hold    = 1'b0;
        hold_go    = 1'b0;
        idle_ok    = 1'b1;
    end

    // ---------------------------------------------------------------
    // Frame decoder
    // ---------------------------------------------------------------
    function automatic logic signed [31:0] widen_payload(logic [31:0] w);
        logic [63:0] mask;
        logic [63:0] v;
        mask = (64'd1 << PAY_BITS) - 64'd1;
        v = {32'd0, w} & mask;
        if (v[PAY_BITS-1]) v = v | ~mask;
        return v[31:0];
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_OWN_ADDRESS:   r_own    = data[ADDR_W-1:0];
            CFG_LISTENER_MODE: r_listen = data[0];
            CFG_PULSE_PERIOD:  r_pulse  = data[PERIOD_W-1:0];
            CFG_BIT_PERIOD:    r_bitp   = data[PERIOD_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void decode_edge(logic [STAMP_W-1:0] stamp, logic lvl);
        logic [31:0] gap;
        t_event_rec  rec;
        bit          matched;
        gap = stamp - prev_stamp;
        // glitch: too close, stored time untouched
        if (64'(gap) < 64'(r_pulse) * 3) return;
        prev_stamp = stamp;
        // long gap starts a new frame
        if (64'(gap) > 64'(r_bitp) * 2) begin
            bits_seen  = '0;
            skip_count = '0;
            shift_reg  = '0;
            return;
        end
        if (skip_count != 0) begin
            skip_count = skip_count - 1'b1;
            return;
        end
        shift_reg = {shift_reg[WORD_W-2:0], lvl};
        bits_seen = bits_seen + 1'b1;
        if (r_listen) begin
            if (bits_seen == CNT_W'(ADDR_BITS)) begin
                matched   = (shift_reg == {{(WORD_W-ADDR_W){1'b0}}, r_own});
                bits_seen = '0;
                shift_reg = '0;
                if (matched) begin
                    rec.kind    = EV_RESPOND;
                    rec.payload = '0;
                    want_events.push_back(rec);
                end else begin
                    skip_count = CNT_W'(PAY_BITS);
                end
            end
            return;
        end
        if (bits_seen == CNT_W'(PAY_BITS)) begin
            rec.kind    = EV_PAYLOAD;
            rec.payload = widen_payload(shift_reg);
            bits_seen   = '0;
            skip_count  = '0;
            shift_reg   = '0;
            want_events.push_back(rec);
        end
    endfunction

    function automatic void report_fail(string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function automatic void check_event(logic kind, logic signed [31:0] value);
        t_event_rec head;
        if (want_events.size() == 0) begin
            report_fail($sformatf("unexpected event kind=%0d payload=%0d", kind, value));
            return;
        end
        head = want_events.pop_front();
        if (kind !== head.kind)
            report_fail($sformatf("event_kind expected %0d got %0d", head.kind, kind));
        if (value !== head.payload)
            report_fail($sformatf("payload expected %0d (0x%08h) got %0d (0x%08h)",
                                  head.payload, head.payload, value, value));
    endfunction

    // ---------------------------------------------------------------
    // Monitor: transfers sampled at the rising edge
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        edge_went = 1'b0;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) apply_reg(cfg_if.index, cfg_if.data);
            if (edge_if.valid && edge_if.ready) begin
                edge_went = 1'b1;
                decode_edge(edge_if.edge_time, edge_if.line_level);
            end
            if (event_if.valid && event_if.ready)
                check_event(event_if.event_kind, event_if.payload);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Edge driver: pops pending edges, random gaps between transfers
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin : drive_edges
        t_edge_item item;
        if (!i_rst_n) begin
            edge_if.valid <= 1'b0;
        end else if (!edge_if.valid || edge_went) begin
            if (send_gap > 0) begin
                send_gap--;
                edge_if.valid <= 1'b0;
            end else if (edge_q.size() != 0) begin
                item = edge_q.pop_front();
                edge_if.valid      <= 1'b1;
                edge_if.edge_time  <= item.stamp;
                edge_if.line_level <= item.level;
                if (idle_ok && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 7);
            end else begin
                edge_if.valid <= 1'b0;
            end
        end
    end

    // Event sink: random stall bursts plus one long hold-off
    always @(negedge i_clk) begin : drive_ready
        if (!i_rst_n || rx_hold) begin
            event_if.ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            event_if.ready <= 1'b0;
        end else if (idle_ok && $urandom_range(0, 7) == 0) begin
            rx_stall = $urandom_range(0, 6);
            event_if.ready <= 1'b0;
        end else begin
            event_if.ready <= 1'b1;
        end
    end

    initial begin : rx_holdoff
        wait (hold_go);
        rx_hold = 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // ---------------------------------------------------------------
    // Edge generation
    // ---------------------------------------------------------------
    function automatic void add_edge(logic [31:0] gap, logic lvl);
        t_edge_item item;
        item.stamp = gen_last + gap;
        item.level = lvl;
        edge_q.push_back(item);
        if (64'(gap) >= 64'(gen_pulse) * 3) begin
            gen_last = item.stamp;
            queued++;
        end
    endfunction

    // gap beyond the frame limit
    function automatic void add_start(logic lvl);
        logic [63:0] lo;
        logic [31:0] gap;
        lo = 64'(gen_bitp) * 2 + 64'd1;
        if (lo < 64'(gen_pulse) * 3) lo = 64'(gen_pulse) * 3;
        case ($urandom_range(0, 3))
            0:       gap = lo[31:0];
            1:       gap = $urandom_range(lo[31:0], 32'hFFFF_FFFF);
            default: gap = lo[31:0] + $urandom_range(0, 400);
        endcase
        add_edge(gap, lvl);
    endfunction

    // gap inside the bit window, sometimes preceded by a glitch
    function automatic void add_bit(logic lvl);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] gap;
        lo = 3 * gen_pulse;
        hi = 2 * gen_bitp;
        if (gen_pulse != 0 && $urandom_range(0, 11) == 0)
            add_edge($urandom_range(0, lo - 1), 1'($urandom_range(0, 1)));
        if (lo > hi) begin
            add_start(lvl);
            return;
        end
        case ($urandom_range(0, 5))
            0:       gap = lo;
            1:       gap = hi;
            default: gap = $urandom_range(lo, hi);
        endcase
        add_edge(gap, lvl);
    endfunction

    function automatic void add_noise();
        case ($urandom_range(0, 3))
            0:       add_edge($urandom, 1'($urandom_range(0, 1)));
            1:       add_edge($urandom_range(0, 3 * gen_pulse), 1'($urandom_range(0, 1)));
            2:       add_bit(1'($urandom_range(0, 1)));
            default: add_start(1'($urandom_range(0, 1)));
        endcase
    endfunction

    function automatic void listener_frame(bit with_start, bit truncate);
        logic [ADDR_W-1:0] addr;
        int n;
        addr = $urandom_range(0, 1) ? gen_own : ADDR_W'($urandom_range(0, 255));
        n = truncate ? $urandom_range(1, ADDR_BITS - 1) : ADDR_BITS;
        if (with_start) add_start(1'($urandom_range(0, 1)));
        for (int i = 0; i < n; i++) add_bit(addr[ADDR_BITS-1-i]);
        // mismatched address: the payload is skipped
        if (!truncate && addr != gen_own)
            for (int i = 0; i < PAY_BITS; i++) add_bit(1'($urandom_range(0, 1)));
    endfunction

    function automatic void caller_frame(bit with_start, bit truncate);
        logic [31:0] word;
        int n;
        case ($urandom_range(0, 7))
            0:       word = 32'h0000_0000;
            1:       word = 32'hFFFF_FFFF;
            2:       word = 32'h8000_0000;
            3:       word = 32'h7FFF_FFFF;
            default: word = $urandom;
        endcase
        n = truncate ? $urandom_range(1, PAY_BITS - 1) : PAY_BITS;
        if (with_start) add_start(1'($urandom_range(0, 1)));
        for (int i = 0; i < n; i++) add_bit(word[PAY_BITS-1-i]);
    endfunction

    function automatic void run_phase(int n_items);
        int stop_at;
        stop_at = queued + n_items;
        while (queued < stop_at) begin
            if ($urandom_range(0, 9) == 0)
                add_noise();
            else if (gen_listen)
                listener_frame($urandom_range(0, 3) != 0, $urandom_range(0, 7) == 0);
            else
                caller_frame($urandom_range(0, 7) != 0, $urandom_range(0, 7) == 0);
        end
    endfunction

    // ---------------------------------------------------------------
    // Register writes, only with the receiver drained
    // ---------------------------------------------------------------
    task automatic settle();
        while (edge_q.size() != 0 || edge_if.valid || want_events.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_regs(logic [ADDR_W-1:0] own, logic listen,
                            logic [PERIOD_W-1:0] pulse, logic [PERIOD_W-1:0] bitp);
        settle();
        write_reg(CFG_OWN_ADDRESS,   CFG_DATA_W'(own));
        write_reg(CFG_LISTENER_MODE, CFG_DATA_W'(listen));
        write_reg(CFG_PULSE_PERIOD,  CFG_DATA_W'(pulse));
        write_reg(CFG_BIT_PERIOD,    CFG_DATA_W'(bitp));
        gen_own    = own;
        gen_listen = listen;
        gen_pulse  = pulse;
        gen_bitp   = bitp;
    endtask

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin : stimulus
        logic [7:0] addr_hit;
        logic [7:0] addr_miss;
        i_rst_n    = 1'b0;
        gen_own    = RST_OWN_ADDRESS;
        gen_listen = 1'b0;
        gen_pulse  = RST_PULSE_PERIOD;
        gen_bitp   = RST_BIT_PERIOD;
        gen_last   = '0;
        queued     = 0;
        addr_hit   = 8'hA5;
        addr_miss  = 8'h5A;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // caller mode at reset values: glitch at time zero, window boundaries, wrap
        add_edge(32'd0, 1'b1);
        add_edge(32'd201, 1'b1);
        add_edge(32'd29, 1'b0);
        add_edge(32'd30, 1'b1);
        add_edge(32'd200, 1'b0);
        add_edge(32'd201, 1'b1);
        add_edge(32'hFFFF_FFE0 - gen_last, 1'b0);
        add_edge(32'd40, 1'b1);

        // listener: matching address, then a miss that skips the payload
        set_regs(addr_hit, 1'b1, 16'd10, 16'd100);
        add_edge(32'd201, 1'b0);
        for (int i = 0; i < 8; i++) add_edge(32'd30 + 32'(i) * 20, addr_hit[7-i]);
        for (int i = 0; i < 8; i++) add_edge(32'd150, addr_miss[7-i]);
        add_edge(32'd30, 1'b1);
        add_edge(32'd31, 1'b0);
        add_edge(32'd500, 1'b1);

        // random phases over several register settings
        set_regs(8'h00, 1'b0, 16'd10, 16'd100);
        hold_go = 1'b1;
        run_phase(250);
        set_regs(8'hFF, 1'b1, 16'd0, 16'd0);
        run_phase(150);
        set_regs(8'h00, 1'b1, 16'd1, 16'd65535);
        run_phase(200);
        set_regs(8'h5A, 1'b0, 16'd65535, 16'd65535);
        run_phase(40);
        set_regs(8'h3C, 1'b0, 16'd21845, 16'd65535);
        run_phase(150);

        // mode change mid-frame: bit count wraps past 64 before the address lands
        set_regs(8'h3C, 1'b0, 16'd5, 16'd50);
        add_start(1'b0);
        for (int i = 0; i < 20; i++) add_bit(1'($urandom_range(0, 1)));
        set_regs(8'h3C, 1'b1, 16'd5, 16'd50);
        for (int i = 0; i < 44; i++) add_bit(1'b0);
        for (int i = 0; i < 8; i++) add_bit(gen_own[7-i]);
        run_phase(120);

        set_regs(ADDR_W'($urandom_range(0, 255)), 1'b1,
                 PERIOD_W'($urandom_range(0, 20)), PERIOD_W'($urandom_range(30, 300)));
        run_phase(200);

        // last stretch runs without idling
        idle_ok = 1'b0;
        set_regs(8'h80, 1'b0, 16'd3, 16'd40);
        run_phase(250);

        settle();
        if (mismatches == 0 && want_events.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
